>>> rtl/dlle_pkg.sv
`timescale 1ns / 1ps

package dlle_pkg;

  localparam int NODES_DEF = 16;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONTAINS  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_LINK,
    ST_UNLINK,
    ST_DONE
  } state_t;

endpackage

>>> rtl/dlle_if.sv
`timescale 1ns / 1ps

interface dlle_in_if import dlle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [ID_W-1:0]  node_id;

  modport source (output valid, cmd, node_id, input ready);
  modport sink (input valid, cmd, node_id, output ready);
endinterface

interface dlle_out_if import dlle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     popped_node;
  logic                found;
  logic [LEN_W-1:0]    length;

  modport source (output valid, status, popped_node, found, length, input ready);
  modport sink (input valid, status, popped_node, found, length, output ready);
endinterface

>>> rtl/doubly_linked_list_engine.sv
`timescale 1ns / 1ps

// Doubly linked list over NODES slots, one command per request on in_chan and one
// result per request on out_chan (registered, so a result may wait while the next
// request is taken). Next and previous links live in two one-port-read RAMs; head,
// tail and length sit in registers. A pop on a non-empty list goes from ST_START
// through ST_UNLINK to ST_DONE. Append, prepend, contains and remove first search
// the list from the head, one next-link RAM read per cycle, until they hit the
// node or reach the end of the list.
// The link RAMs need no initialization after reset: only linked slots are read.
module doubly_linked_list_engine import dlle_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dlle_in_if.sink       in_chan,
  dlle_out_if.source    out_chan
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(NODES + 1);
  localparam logic [LW-1:0] NIL = LW'(NODES);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0] cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [LW-1:0]    s_r, s_nxt;
  logic [LW-1:0]    head_r, head_nxt;
  logic [LW-1:0]    tail_r, tail_nxt;
  logic [LW-1:0]    count_r, count_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_popped_r, res_popped_nxt;
  logic                res_found_r, res_found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_popped_r;
  logic                out_found_r;
  logic [LEN_W-1:0]    out_length_r;

  logic          nm_we, pm_we;
  logic [AW-1:0] nm_waddr, pm_waddr;
  logic [LW-1:0] nm_wdata, pm_wdata;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] nm_rdata, pm_rdata;

  logic          in_acc;
  logic          out_load;
  logic          id_ok;
  logic [LW-1:0] id_l;
  logic          is_pop;
  logic          is_search;
  logic          is_link_cmd;
  logic          searching;
  logic [LW-1:0] srch_cur;
  logic          srch_hit;
  logic          srch_miss;
  logic [LW-1:0] pop_slot;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  assign id_ok       = 32'(id_r) < 32'(NODES);
  assign id_l        = LW'(id_r);
  assign is_pop      = (cmd_r == CMD_POP_FRONT) || (cmd_r == CMD_POP_BACK);
  assign is_link_cmd = (cmd_r == CMD_APPEND) || (cmd_r == CMD_PREPEND);
  assign is_search   = is_link_cmd || (cmd_r == CMD_CONTAINS) || (cmd_r == CMD_REMOVE);
  assign searching   = ((state_r == ST_START) && is_search && id_ok) || (state_r == ST_WALK);
  assign srch_cur    = (state_r == ST_WALK) ? nm_rdata : head_r;
  assign srch_hit    = (srch_cur == id_l);
  assign srch_miss   = (srch_cur == NIL);
  assign pop_slot    = (cmd_r == CMD_POP_FRONT) ? head_r : tail_r;
  assign rd_addr     = is_pop ? pop_slot[AW-1:0] : srch_cur[AW-1:0];
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  dlle_link_ram #(.DEPTH(NODES), .AW(AW), .DW(LW)) u_next_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (rd_addr),
    .rdata (nm_rdata)
  );

  dlle_link_ram #(.DEPTH(NODES), .AW(AW), .DW(LW)) u_prev_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (rd_addr),
    .rdata (pm_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_START;
        end
      end
      ST_START, ST_WALK: begin
        if (searching) begin
          if (srch_hit) begin
            state_nxt = (cmd_r == CMD_REMOVE) ? ST_UNLINK : ST_DONE;
          end else if (srch_miss) begin
            state_nxt = is_link_cmd ? ST_LINK : ST_DONE;
          end else begin
            state_nxt = ST_WALK;
          end
        end else if (is_pop && (pop_slot != NIL)) begin
          state_nxt = ST_UNLINK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LINK: begin
        state_nxt = ST_DONE;
      end
      ST_UNLINK: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and link ram writes
  always_comb begin
    nm_we          = 1'b0;
    nm_waddr       = id_l[AW-1:0];
    nm_wdata       = NIL;
    pm_we          = 1'b0;
    pm_waddr       = id_l[AW-1:0];
    pm_wdata       = NIL;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    s_nxt          = s_r;
    res_status_nxt = res_status_r;
    res_popped_nxt = res_popped_r;
    res_found_nxt  = res_found_r;

    unique case (state_r)
      ST_START, ST_WALK: begin
        if (state_r == ST_START) begin
          res_status_nxt = STATUS_OK;
          res_popped_nxt = '0;
          res_found_nxt  = 1'b0;
          s_nxt          = is_pop ? pop_slot : id_l;
          if (is_pop && (pop_slot == NIL)) begin
            res_status_nxt = STATUS_EMPTY;
          end
        end
        if (searching) begin
          if (srch_hit) begin
            if (is_link_cmd) begin
              res_status_nxt = STATUS_PRESENT;
            end
            if (cmd_r == CMD_CONTAINS) begin
              res_found_nxt = 1'b1;
            end
          end else if (srch_miss) begin
            if (cmd_r == CMD_APPEND) begin
              nm_we    = 1'b1;
              nm_wdata = NIL;
              pm_we    = 1'b1;
              pm_wdata = tail_r;
            end else if (cmd_r == CMD_PREPEND) begin
              pm_we    = 1'b1;
              pm_wdata = NIL;
              nm_we    = 1'b1;
              nm_wdata = head_r;
            end
          end
        end
      end
      ST_LINK: begin
        count_nxt = count_r + 1'b1;
        if (cmd_r == CMD_APPEND) begin
          if (tail_r != NIL) begin
            nm_we    = 1'b1;
            nm_waddr = tail_r[AW-1:0];
            nm_wdata = id_l;
          end else begin
            head_nxt = id_l;
          end
          tail_nxt = id_l;
        end else begin
          if (head_r != NIL) begin
            pm_we    = 1'b1;
            pm_waddr = head_r[AW-1:0];
            pm_wdata = id_l;
          end else begin
            tail_nxt = id_l;
          end
          head_nxt = id_l;
        end
      end
      ST_UNLINK: begin
        if (pm_rdata != NIL) begin
          nm_we    = 1'b1;
          nm_waddr = pm_rdata[AW-1:0];
          nm_wdata = nm_rdata;
        end
        if (nm_rdata != NIL) begin
          pm_we    = 1'b1;
          pm_waddr = nm_rdata[AW-1:0];
          pm_wdata = pm_rdata;
        end
        if (head_r == s_r) begin
          head_nxt = nm_rdata;
        end
        if (tail_r == s_r) begin
          tail_nxt = pm_rdata;
        end
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        if (is_pop) begin
          res_popped_nxt = ID_W'(s_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_chan.cmd;
      id_r  <= in_chan.node_id;
    end
    s_r          <= s_nxt;
    res_status_r <= res_status_nxt;
    res_popped_r <= res_popped_nxt;
    res_found_r  <= res_found_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_popped_r <= res_popped_r;
      out_found_r  <= res_found_r;
      out_length_r <= LEN_W'(count_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.popped_node = out_popped_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.length      = out_length_r;

  a_ends_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r == NIL) == (count_r == '0)) && ((tail_r == NIL) == (count_r == '0)))
    else $error("head or tail null state disagrees with length");

  a_single_node: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == LW'(1)) |-> (head_r == tail_r))
    else $error("one-node list with different head and tail");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_START))
    else $error("accepted request did not start processing");

  a_unlink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNLINK) |-> ((count_r != '0) && (s_r != NIL)))
    else $error("unlink on empty list or null slot");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside completion");

endmodule

>>> rtl/dlle_link_ram.sv
`timescale 1ns / 1ps

module dlle_link_ram import dlle_pkg::*; #(
  parameter int DEPTH = NODES_DEF,
  parameter int AW    = 4,
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
